### src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MMA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition must never be true
`define MMA_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

`endif

### src/mma_pkg.sv
// shared types and constants of the montgomery modular alu
package mma_pkg;

    localparam int MOD_W   = 30;
    localparam int VAL_W   = 31;
    localparam int CMD_W   = 4;
    localparam int INT_W   = 64;
    localparam int RADIX_W = 32;

    localparam logic [MOD_W-1:0] RESET_MODULUS = 30'd998244353;
    localparam logic [2:0]       NEWTON_LAST   = 3'd5;
    localparam logic [5:0]       REM_LAST      = 6'd63;

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_SKIP    = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CONVERT = 4'd0,
        CMD_ADD     = 4'd1,
        CMD_SUB     = 4'd2,
        CMD_MUL     = 4'd3,
        CMD_DIV     = 4'd4,
        CMD_POW     = 4'd5,
        CMD_INV     = 4'd6,
        CMD_NEG     = 4'd7,
        CMD_CANON   = 4'd8,
        CMD_EQUAL   = 4'd9
    } mma_cmd_t;

    typedef enum logic [2:0] {
        MM_IDLE,
        MM_LO,
        MM_HI,
        MM_T,
        MM_Q,
        MM_SUM
    } mma_mont_phase_t;

    typedef enum logic [3:0] {
        ST_DERIVE,
        ST_DERIVE_WAIT,
        ST_IDLE,
        ST_CONV_REM,
        ST_MUL_WAIT,
        ST_CAN_WAIT,
        ST_EQA_WAIT,
        ST_EQB_WAIT,
        ST_POW_INIT,
        ST_POW_LOOP,
        ST_POW_MULW,
        ST_POW_SQW,
        ST_OUT
    } mma_state_t;

    typedef struct packed {
        logic               start;
        logic               wide;
        logic [INT_W-1:0]   x;
        logic [RADIX_W-1:0] y;
    } mma_mont_req_t;

    typedef struct packed {
        logic             start;
        logic [MOD_W-1:0] init;
        logic [INT_W-1:0] dividend;
    } mma_rem_req_t;

endpackage

### src/mma_ifs.sv
// request and result channel interfaces

interface mma_req_if;
    logic                              valid;
    logic                              ready;
    logic [mma_pkg::CMD_W-1:0]         command;
    logic [mma_pkg::VAL_W-1:0]         operand_a;
    logic [mma_pkg::VAL_W-1:0]         operand_b;
    logic signed [mma_pkg::INT_W-1:0]  plain_integer;
    logic signed [mma_pkg::INT_W-1:0]  exponent;

    modport source (output valid, command, operand_a, operand_b, plain_integer, exponent,
                    input ready);
    modport sink (input valid, command, operand_a, operand_b, plain_integer, exponent,
                  output ready);
endinterface

interface mma_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [mma_pkg::VAL_W-1:0] result_value;
    logic                      is_equal;

    modport source (output valid, result_value, is_equal, input ready);
    modport sink (input valid, result_value, is_equal, output ready);
endinterface

### src/mma_newton.sv
// newton iteration for the inverse of the modulus mod 2^32
module mma_newton (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mma_pkg::MOD_W-1:0]    modulus,
    output logic                         busy,
    output logic [mma_pkg::RADIX_W-1:0]  factor
);

    logic                        busy_reg;
    logic                        phase_reg;
    logic [2:0]                  iter_reg;
    logic [mma_pkg::RADIX_W-1:0] x_reg;
    logic [mma_pkg::RADIX_W-1:0] p_reg;
    logic [mma_pkg::RADIX_W-1:0] mul_a;
    logic [mma_pkg::RADIX_W-1:0] mul_b;
    logic [mma_pkg::RADIX_W-1:0] prod_lo;

    assign mul_a   = x_reg;
    assign mul_b   = phase_reg ? (32'd2 - p_reg) : {2'b00, modulus};
    assign prod_lo = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            iter_reg  <= 3'd0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
            iter_reg  <= 3'd0;
        end
        else if (busy_reg)
        begin
            phase_reg <= ~phase_reg;
            if (phase_reg)
            begin
                iter_reg <= iter_reg + 3'd1;
                if (iter_reg == mma_pkg::NEWTON_LAST)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            x_reg <= 32'd1;
        else if (busy_reg)
        begin
            if (phase_reg)
                x_reg <= prod_lo;
            else
                p_reg <= prod_lo;
        end
    end

    assign busy   = busy_reg;
    assign factor = x_reg;

endmodule

### src/mma_serrem.sv
// bit-serial remainder: one dividend bit per cycle, msb first
module mma_serrem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mma_pkg::mma_rem_req_t      req,
    input  logic [mma_pkg::MOD_W-1:0]  modulus,
    output logic                       busy,
    output logic [mma_pkg::MOD_W-1:0]  rem
);

    logic                        busy_reg;
    logic [5:0]                  count_reg;
    logic [mma_pkg::MOD_W-1:0]   rem_reg;
    logic [mma_pkg::INT_W-1:0]   div_reg;
    logic [mma_pkg::MOD_W:0]     cand;
    logic [mma_pkg::MOD_W:0]     reduced;

    assign cand    = {rem_reg, div_reg[mma_pkg::INT_W-1]};
    assign reduced = (cand >= {1'b0, modulus}) ? (cand - {1'b0, modulus}) : cand;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= 6'd0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= 6'd0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 6'd1;
            if (count_reg == mma_pkg::REM_LAST)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.init;
            div_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= reduced[mma_pkg::MOD_W-1:0];
            div_reg <= {div_reg[mma_pkg::INT_W-2:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

### src/mma_mont.sv
// montgomery product engine on one shared 32x32 multiplier
module mma_mont (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mma_pkg::mma_mont_req_t       req,
    input  logic [mma_pkg::MOD_W-1:0]    modulus,
    input  logic [mma_pkg::RADIX_W-1:0]  factor,
    output logic                         busy,
    output logic                         done,
    output logic [mma_pkg::RADIX_W-1:0]  res
);

    mma_pkg::mma_mont_phase_t phase_reg, phase_next;

    logic                        wide_reg;
    logic                        done_reg;
    logic [mma_pkg::INT_W-1:0]   x_reg;
    logic [mma_pkg::RADIX_W-1:0] y_reg;
    logic [mma_pkg::INT_W-1:0]   w_reg;
    logic [mma_pkg::RADIX_W-1:0] t_reg;
    logic [mma_pkg::RADIX_W-1:0] qh_reg;
    logic [mma_pkg::RADIX_W-1:0] res_reg;
    logic [mma_pkg::RADIX_W-1:0] mul_a;
    logic [mma_pkg::RADIX_W-1:0] mul_b;
    logic [mma_pkg::INT_W-1:0]   prod;

    always_comb
    begin
        mul_a      = x_reg[31:0];
        mul_b      = y_reg;
        phase_next = phase_reg;
        unique case (phase_reg)
            mma_pkg::MM_IDLE:
            begin
                if (req.start)
                    phase_next = mma_pkg::MM_LO;
            end
            mma_pkg::MM_LO:
            begin
                phase_next = wide_reg ? mma_pkg::MM_HI : mma_pkg::MM_T;
            end
            mma_pkg::MM_HI:
            begin
                mul_a      = x_reg[63:32];
                phase_next = mma_pkg::MM_T;
            end
            mma_pkg::MM_T:
            begin
                mul_a      = w_reg[31:0];
                mul_b      = factor;
                phase_next = mma_pkg::MM_Q;
            end
            mma_pkg::MM_Q:
            begin
                mul_a      = t_reg;
                mul_b      = {2'b00, modulus};
                phase_next = mma_pkg::MM_SUM;
            end
            mma_pkg::MM_SUM:
            begin
                phase_next = mma_pkg::MM_IDLE;
            end
            default:
            begin
                phase_next = mma_pkg::MM_IDLE;
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mma_pkg::MM_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == mma_pkg::MM_SUM);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            mma_pkg::MM_IDLE:
            begin
                if (req.start)
                begin
                    wide_reg <= req.wide;
                    x_reg    <= req.x;
                    y_reg    <= req.y;
                end
            end
            mma_pkg::MM_LO:  w_reg <= prod;
            // upper partial product only lands in the high word, wrapped to 64 bits
            mma_pkg::MM_HI:  w_reg[63:32] <= w_reg[63:32] + prod[31:0];
            mma_pkg::MM_T:   t_reg <= prod[31:0];
            mma_pkg::MM_Q:   qh_reg <= prod[63:32];
            mma_pkg::MM_SUM: res_reg <= w_reg[63:32] + {2'b00, modulus} - qh_reg;
            default:
            begin
            end
        endcase
    end

    assign busy = (phase_reg != mma_pkg::MM_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

endmodule

### src/montgomery_modular_alu_core.sv
// top level of the montgomery modular alu
//
// req_in carries one command with its operands; rsp_out returns one result per
// request, in order. both use valid/ready and move a request on a cycle where
// both are high. cfg_we/cfg_index/cfg_data write modulus (index 0) or
// skip_normalize (index 1); write only while no request is in flight.
// one request is worked on at a time: add, sub, negate and unused codes need
// no product, mul and canonical one, equal two, conversion a bit-serial
// remainder and one product, or a single wide product in fast mode; pow
// seeds the accumulator with one product, then squares once per exponent bit
// and multiplies once more per set bit, up to its highest set bit; inverse
// and divide use the 30-bit exponent modulus-2, divide adds one more product.
// each montgomery product runs on the single 32x32 multiplier.
// after reset and after every modulus write the block derives the montgomery
// factor and r^2 mod m, limited by the 64-step serial remainder, and takes no
// request meanwhile.
// a finished result sits in the output register; a new request is accepted
// while it waits, and the next result holds until the receiver takes the first.
`include "assert_macros.svh"

module montgomery_modular_alu_core (
    input  logic                       clk,
    input  logic                       rst_n,
    mma_req_if.sink                    req_in,
    mma_rsp_if.source                  rsp_out,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [mma_pkg::MOD_W-1:0]  cfg_data
);

    mma_pkg::mma_state_t state_reg, state_next;
    mma_pkg::mma_cmd_t   in_cmd;
    mma_pkg::mma_cmd_t   cmd_reg;

    mma_pkg::mma_mont_req_t mont_req;
    mma_pkg::mma_rem_req_t  rem_req;

    logic                        mont_busy;
    logic                        mont_done;
    logic [mma_pkg::RADIX_W-1:0] mont_res;
    logic                        rem_busy;
    logic [mma_pkg::MOD_W-1:0]   rem_val;
    logic                        newton_start;
    logic                        newton_busy;
    logic [mma_pkg::RADIX_W-1:0] factor;

    logic [mma_pkg::MOD_W-1:0]   modulus_reg;
    logic [mma_pkg::MOD_W-1:0]   mod_eff;
    logic                        skip_reg;
    logic [mma_pkg::MOD_W-1:0]   r2_reg;

    logic [mma_pkg::VAL_W-1:0]   a_reg;
    logic [mma_pkg::VAL_W-1:0]   b_reg;
    logic                        neg_reg;
    logic [mma_pkg::VAL_W-1:0]   acc_reg;
    logic [mma_pkg::VAL_W-1:0]   base_reg;
    logic [mma_pkg::INT_W-1:0]   exp_reg;
    logic [mma_pkg::MOD_W-1:0]   ca_reg;
    logic [mma_pkg::VAL_W-1:0]   res_reg;
    logic                        eq_reg;

    logic                        out_valid_reg;
    logic [mma_pkg::VAL_W-1:0]   out_res_reg;
    logic                        out_eq_reg;

    logic                        accept;
    logic                        load_out;
    logic [mma_pkg::INT_W-1:0]   y_u;
    logic [mma_pkg::INT_W-1:0]   y_abs;
    logic [mma_pkg::MOD_W-1:0]   conv_v;
    logic [mma_pkg::MOD_W-1:0]   canon;
    logic [mma_pkg::RADIX_W-1:0] twom;
    logic [mma_pkg::RADIX_W-1:0] add_raw;
    logic [mma_pkg::RADIX_W-1:0] sub_raw;
    logic [mma_pkg::RADIX_W-1:0] neg_raw;
    logic [mma_pkg::RADIX_W-1:0] add_fix;
    logic [mma_pkg::RADIX_W-1:0] sub_fix;
    logic [mma_pkg::RADIX_W-1:0] neg_fix;
    logic [mma_pkg::VAL_W-1:0]   alu_res;

    mma_mont u_mont (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mont_req),
        .modulus (modulus_reg),
        .factor  (factor),
        .busy    (mont_busy),
        .done    (mont_done),
        .res     (mont_res)
    );

    mma_serrem u_serrem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (rem_req),
        .modulus (modulus_reg),
        .busy    (rem_busy),
        .rem     (rem_val)
    );

    mma_newton u_newton (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (newton_start),
        .modulus (modulus_reg),
        .busy    (newton_busy),
        .factor  (factor)
    );

    // even modulus gets bit 0 forced; zero and one become three
    assign mod_eff = ((cfg_data | 30'd1) == 30'd1) ? 30'd3 : (cfg_data | 30'd1);

    assign in_cmd = mma_pkg::mma_cmd_t'(req_in.command);
    assign y_u    = req_in.plain_integer;
    assign y_abs  = y_u[63] ? (64'd0 - y_u) : y_u;
    assign conv_v = !neg_reg ? rem_val :
                    ((rem_val == 30'd0) ? 30'd0 : (modulus_reg - rem_val));
    assign canon  = (mont_res >= {2'b00, modulus_reg}) ?
                    30'(mont_res - {2'b00, modulus_reg}) : mont_res[29:0];

    // lazy add/sub/negate in 32 bits with one correction by 2m
    assign twom    = {1'b0, modulus_reg, 1'b0};
    assign add_raw = {1'b0, req_in.operand_a} + {1'b0, req_in.operand_b} - twom;
    assign sub_raw = {1'b0, req_in.operand_a} - {1'b0, req_in.operand_b};
    assign neg_raw = 32'd0 - {1'b0, req_in.operand_a};
    assign add_fix = add_raw[31] ? (add_raw + twom) : add_raw;
    assign sub_fix = sub_raw[31] ? (sub_raw + twom) : sub_raw;
    assign neg_fix = neg_raw[31] ? (neg_raw + twom) : neg_raw;

    always_comb
    begin
        unique case (in_cmd)
            mma_pkg::CMD_ADD: alu_res = add_fix[30:0];
            mma_pkg::CMD_SUB: alu_res = sub_fix[30:0];
            mma_pkg::CMD_NEG: alu_res = neg_fix[30:0];
            default:          alu_res = 31'd0;
        endcase
    end

    assign accept = req_in.valid && req_in.ready;

    always_comb
    begin
        state_next   = state_reg;
        mont_req     = '0;
        rem_req      = '0;
        newton_start = 1'b0;
        load_out     = 1'b0;
        req_in.ready = 1'b0;
        unique case (state_reg)
            mma_pkg::ST_DERIVE:
            begin
                newton_start = 1'b1;
                rem_req.start = 1'b1;
                rem_req.init  = 30'd1;
                state_next    = mma_pkg::ST_DERIVE_WAIT;
            end
            mma_pkg::ST_DERIVE_WAIT:
            begin
                if (!newton_busy && !rem_busy)
                    state_next = mma_pkg::ST_IDLE;
            end
            mma_pkg::ST_IDLE:
            begin
                req_in.ready = 1'b1;
                if (req_in.valid)
                begin
                    unique case (in_cmd)
                        mma_pkg::CMD_CONVERT:
                        begin
                            if (skip_reg)
                            begin
                                mont_req.start = 1'b1;
                                mont_req.wide  = 1'b1;
                                mont_req.x     = y_u;
                                mont_req.y     = {2'b00, r2_reg};
                                state_next     = mma_pkg::ST_MUL_WAIT;
                            end
                            else
                            begin
                                rem_req.start    = 1'b1;
                                rem_req.dividend = y_abs;
                                state_next       = mma_pkg::ST_CONV_REM;
                            end
                        end
                        mma_pkg::CMD_MUL:
                        begin
                            mont_req.start = 1'b1;
                            mont_req.x     = {33'd0, req_in.operand_a};
                            mont_req.y     = {1'b0, req_in.operand_b};
                            state_next     = mma_pkg::ST_MUL_WAIT;
                        end
                        mma_pkg::CMD_DIV, mma_pkg::CMD_POW, mma_pkg::CMD_INV:
                        begin
                            // one in montgomery form seeds the accumulator
                            mont_req.start = 1'b1;
                            mont_req.x     = 64'd1;
                            mont_req.y     = {2'b00, r2_reg};
                            state_next     = mma_pkg::ST_POW_INIT;
                        end
                        mma_pkg::CMD_CANON:
                        begin
                            mont_req.start = 1'b1;
                            mont_req.x     = {33'd0, req_in.operand_a};
                            mont_req.y     = 32'd1;
                            state_next     = mma_pkg::ST_CAN_WAIT;
                        end
                        mma_pkg::CMD_EQUAL:
                        begin
                            mont_req.start = 1'b1;
                            mont_req.x     = {33'd0, req_in.operand_a};
                            mont_req.y     = 32'd1;
                            state_next     = mma_pkg::ST_EQA_WAIT;
                        end
                        default:
                        begin
                            state_next = mma_pkg::ST_OUT;
                        end
                    endcase
                end
            end
            mma_pkg::ST_CONV_REM:
            begin
                if (!rem_busy)
                begin
                    mont_req.start = 1'b1;
                    mont_req.x     = {34'd0, conv_v};
                    mont_req.y     = {2'b00, r2_reg};
                    state_next     = mma_pkg::ST_MUL_WAIT;
                end
            end
            mma_pkg::ST_MUL_WAIT, mma_pkg::ST_CAN_WAIT, mma_pkg::ST_EQB_WAIT:
            begin
                if (mont_done)
                    state_next = mma_pkg::ST_OUT;
            end
            mma_pkg::ST_EQA_WAIT:
            begin
                if (mont_done)
                begin
                    mont_req.start = 1'b1;
                    mont_req.x     = {33'd0, b_reg};
                    mont_req.y     = 32'd1;
                    state_next     = mma_pkg::ST_EQB_WAIT;
                end
            end
            mma_pkg::ST_POW_INIT:
            begin
                if (mont_done)
                    state_next = mma_pkg::ST_POW_LOOP;
            end
            mma_pkg::ST_POW_LOOP:
            begin
                if (exp_reg == 64'd0)
                begin
                    if (cmd_reg == mma_pkg::CMD_DIV)
                    begin
                        mont_req.start = 1'b1;
                        mont_req.x     = {33'd0, a_reg};
                        mont_req.y     = {1'b0, acc_reg};
                        state_next     = mma_pkg::ST_MUL_WAIT;
                    end
                    else
                    begin
                        state_next = mma_pkg::ST_OUT;
                    end
                end
                else if (exp_reg[0])
                begin
                    mont_req.start = 1'b1;
                    mont_req.x     = {33'd0, acc_reg};
                    mont_req.y     = {1'b0, base_reg};
                    state_next     = mma_pkg::ST_POW_MULW;
                end
                else
                begin
                    mont_req.start = 1'b1;
                    mont_req.x     = {33'd0, base_reg};
                    mont_req.y     = {1'b0, base_reg};
                    state_next     = mma_pkg::ST_POW_SQW;
                end
            end
            mma_pkg::ST_POW_MULW:
            begin
                if (mont_done)
                begin
                    mont_req.start = 1'b1;
                    mont_req.x     = {33'd0, base_reg};
                    mont_req.y     = {1'b0, base_reg};
                    state_next     = mma_pkg::ST_POW_SQW;
                end
            end
            mma_pkg::ST_POW_SQW:
            begin
                if (mont_done)
                    state_next = mma_pkg::ST_POW_LOOP;
            end
            mma_pkg::ST_OUT:
            begin
                if (!out_valid_reg || rsp_out.ready)
                begin
                    load_out   = 1'b1;
                    state_next = mma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mma_pkg::ST_DERIVE;
            end
        endcase
        // a new modulus restarts the derivation
        if (cfg_we && cfg_index == mma_pkg::CFG_MODULUS)
            state_next = mma_pkg::ST_DERIVE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mma_pkg::ST_DERIVE;
            modulus_reg   <= mma_pkg::RESET_MODULUS;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mma_pkg::CFG_MODULUS: modulus_reg <= mod_eff;
                    mma_pkg::CFG_SKIP:    skip_reg    <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_res_reg <= res_reg;
            out_eq_reg  <= eq_reg;
        end
        unique case (state_reg)
            mma_pkg::ST_DERIVE_WAIT:
            begin
                if (!newton_busy && !rem_busy)
                    r2_reg <= rem_val;
            end
            mma_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg  <= in_cmd;
                    a_reg    <= req_in.operand_a;
                    b_reg    <= req_in.operand_b;
                    neg_reg  <= y_u[63];
                    eq_reg   <= 1'b0;
                    res_reg  <= alu_res;
                    base_reg <= (in_cmd == mma_pkg::CMD_DIV) ? req_in.operand_b
                                                             : req_in.operand_a;
                    if (in_cmd == mma_pkg::CMD_POW)
                        exp_reg <= req_in.exponent[63] ? 64'd0 : req_in.exponent;
                    else
                        exp_reg <= {34'd0, modulus_reg - 30'd2};
                end
            end
            mma_pkg::ST_MUL_WAIT:
            begin
                if (mont_done)
                    res_reg <= mont_res[30:0];
            end
            mma_pkg::ST_CAN_WAIT:
            begin
                if (mont_done)
                    res_reg <= {1'b0, canon};
            end
            mma_pkg::ST_EQA_WAIT:
            begin
                if (mont_done)
                    ca_reg <= canon;
            end
            mma_pkg::ST_EQB_WAIT:
            begin
                if (mont_done)
                    eq_reg <= (canon == ca_reg);
            end
            mma_pkg::ST_POW_INIT, mma_pkg::ST_POW_MULW:
            begin
                if (mont_done)
                    acc_reg <= mont_res[30:0];
            end
            mma_pkg::ST_POW_LOOP:
            begin
                if (exp_reg == 64'd0)
                    res_reg <= acc_reg;
            end
            mma_pkg::ST_POW_SQW:
            begin
                if (mont_done)
                begin
                    base_reg <= mont_res[30:0];
                    exp_reg  <= {1'b0, exp_reg[63:1]};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_out.valid        = out_valid_reg;
    assign rsp_out.result_value = out_res_reg;
    assign rsp_out.is_equal     = out_eq_reg;

    `MMA_ASSERT_IMP(a_mont_start_free, mont_req.start, !mont_busy)
    `MMA_ASSERT_NEVER(a_mod_odd, modulus_reg[0] == 1'b0)
    `MMA_ASSERT_IMP(a_idle_units_free, state_reg == mma_pkg::ST_IDLE, !mont_busy && !rem_busy)
    `MMA_ASSERT_IMP(a_done_when_waiting, mont_done, state_reg == mma_pkg::ST_MUL_WAIT || state_reg == mma_pkg::ST_CAN_WAIT || state_reg == mma_pkg::ST_EQA_WAIT || state_reg == mma_pkg::ST_EQB_WAIT || state_reg == mma_pkg::ST_POW_INIT || state_reg == mma_pkg::ST_POW_MULW || state_reg == mma_pkg::ST_POW_SQW || state_reg == mma_pkg::ST_DERIVE || state_reg == mma_pkg::ST_DERIVE_WAIT)

endmodule
